[rtl/cvfr_pkg.sv]
// ----------------------------------------------------------------------------
// cvfr_pkg: shared types and constants for the velocity frame receiver
// Frame layout, the CRC16 byte step and the frame record that the front end
// passes through the queue to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package cvfr_pkg;

    // Frame layout
    localparam int PAYLOAD_BYTES = 13;
    localparam int POS_W         = 5;
    localparam int IDX_W         = $clog2(PAYLOAD_BYTES);

    localparam logic [POS_W-1:0] POS_HUNT    = '0;
    localparam logic [POS_W-1:0] POS_LAST_PL = POS_W'(PAYLOAD_BYTES);
    localparam logic [POS_W-1:0] POS_CRC_HI  = POS_W'(PAYLOAD_BYTES + 1);
    localparam logic [POS_W-1:0] POS_CRC_LO  = POS_W'(PAYLOAD_BYTES + 2);

    // Byte offsets of the fields inside the payload
    localparam int VX_BASE   = 0;
    localparam int VY_BASE   = 4;
    localparam int WZ_BASE   = 8;
    localparam int FLAG_BYTE = PAYLOAD_BYTES - 1;
    localparam int COLOR_BIT = 0;
    localparam int START_BIT = 1;

    // Register reset and CRC constants
    localparam logic [7:0]  START_BYTE_RESET = 8'h5A;
    localparam logic [15:0] CRC_INIT         = 16'hFFFF;
    localparam logic [15:0] CRC_POLY         = 16'hA001;

    // Frame queue geometry
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Role of a received byte, set by its place in the frame
    typedef enum logic [1:0] {
        BK_HUNT,
        BK_PAYLOAD,
        BK_CRC_HI,
        BK_CRC_LO
    } t_byte_kind;

    // One completed frame, as handed from front end to back end
    typedef struct packed {
        logic [31:0] vx_bits;
        logic [31:0] vy_bits;
        logic [31:0] wz_bits;
        logic        crc_ok;
        logic        color_flag;
        logic        start_flag;
    } t_frame;

    // Queue handshake seen by the back end
    typedef struct packed {
        logic   empty;
        t_frame head;
    } t_q_status;

    // Modbus CRC16, one byte, eight bit steps unrolled
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/cvfr_queue.sv]
// ----------------------------------------------------------------------------
// cvfr_queue: short frame queue
// Holds completed frame records between the byte front end and the result
// back end so that each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module cvfr_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  cvfr_pkg::t_frame        i_push_data,
    output logic                    o_full,
    input  wire logic               i_pop,
    output cvfr_pkg::t_q_status     o_status
);
    import cvfr_pkg::*;

    t_frame               r_entry [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count,  n_count;
    logic                 do_push, do_pop;

    assign o_full          = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_status.empty  = (r_count == '0);
    assign o_status.head   = r_entry[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_status.empty;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed record
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

[rtl/cvfr_front.sv]
// ----------------------------------------------------------------------------
// cvfr_front: byte front end
// Hunts for the start byte, classifies each byte by its place in the frame,
// runs the CRC16 and pushes one record per completed frame.
// ----------------------------------------------------------------------------
`default_nettype none

module cvfr_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [7:0]         i_rx_byte,
    input  wire logic               i_cfg_write,
    input  wire logic [7:0]         i_cfg_start_byte,
    output logic                    o_push,
    output cvfr_pkg::t_frame        o_push_data
);
    import cvfr_pkg::*;

    logic [7:0]        r_start_byte;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [15:0]       r_crc, n_crc;
    logic [7:0]        r_payload [PAYLOAD_BYTES];
    logic [7:0]        r_crc_high;
    logic [15:0]       crc_next_byte;
    logic [IDX_W-1:0]  wr_idx;
    logic              crc_match;
    t_byte_kind        kind;

    // Classify the byte by frame position
    always_comb begin
        if (r_pos == POS_HUNT) begin
            kind = BK_HUNT;
        end else if (r_pos <= POS_LAST_PL) begin
            kind = BK_PAYLOAD;
        end else if (r_pos == POS_CRC_HI) begin
            kind = BK_CRC_HI;
        end else begin
            kind = BK_CRC_LO;
        end
    end

    assign crc_next_byte = crc_feed(r_crc, i_rx_byte);
    assign wr_idx        = IDX_W'(r_pos - POS_W'(1));
    assign crc_match     = (r_crc_high == r_crc[15:8]) && (i_rx_byte == r_crc[7:0]);

    // Next position and CRC
    always_comb begin
        n_pos  = r_pos;
        n_crc  = r_crc;
        o_push = 1'b0;
        if (i_accept) begin
            unique case (kind)
                BK_HUNT: begin
                    if (i_rx_byte == r_start_byte) begin
                        n_pos = POS_W'(1);
                        n_crc = CRC_INIT;
                    end
                end
                BK_PAYLOAD: begin
                    n_crc = crc_next_byte;
                    n_pos = r_pos + 1'b1;
                end
                BK_CRC_HI: begin
                    n_pos = r_pos + 1'b1;
                end
                BK_CRC_LO: begin
                    o_push = 1'b1;
                    n_pos  = POS_HUNT;
                    n_crc  = CRC_INIT;
                end
                default: begin
                    n_pos = POS_HUNT;
                end
            endcase
        end
    end

    // Assemble the frame record from the stored payload
    always_comb begin
        o_push_data.vx_bits    = {r_payload[VX_BASE+3], r_payload[VX_BASE+2],
                                  r_payload[VX_BASE+1], r_payload[VX_BASE]};
        o_push_data.vy_bits    = {r_payload[VY_BASE+3], r_payload[VY_BASE+2],
                                  r_payload[VY_BASE+1], r_payload[VY_BASE]};
        o_push_data.wz_bits    = {r_payload[WZ_BASE+3], r_payload[WZ_BASE+2],
                                  r_payload[WZ_BASE+1], r_payload[WZ_BASE]};
        o_push_data.crc_ok     = crc_match;
        o_push_data.color_flag = r_payload[FLAG_BYTE][COLOR_BIT];
        o_push_data.start_flag = r_payload[FLAG_BYTE][START_BIT];
    end

    // Control state and start byte register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= POS_HUNT;
            r_crc        <= CRC_INIT;
            r_start_byte <= START_BYTE_RESET;
        end else begin
            r_pos <= n_pos;
            r_crc <= n_crc;
            if (i_cfg_write) begin
                r_start_byte <= i_cfg_start_byte;
            end
        end
    end

    // Capture payload and high CRC byte
    always_ff @(posedge i_clk) begin
        if (i_accept && kind == BK_PAYLOAD) begin
            r_payload[wr_idx] <= i_rx_byte;
        end
        if (i_accept && kind == BK_CRC_HI) begin
            r_crc_high <= i_rx_byte;
        end
    end

endmodule

`default_nettype wire

[rtl/cvfr_back.sv]
// ----------------------------------------------------------------------------
// cvfr_back: result back end
// Pops frame records, keeps the last good velocities and drives the result
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cvfr_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  cvfr_pkg::t_q_status     i_q,
    output logic                    o_pop,
    input  wire logic               i_out_stall,
    output logic                    o_out_valid,
    output cvfr_pkg::t_frame        o_result
);
    import cvfr_pkg::*;

    logic [31:0] r_held_vx, r_held_vy, r_held_wz;
    logic        r_out_valid;
    t_frame      r_result;
    logic        load;

    // Take a record when the output register is free or being drained
    assign load        = !i_q.empty && (!r_out_valid || !i_out_stall);
    assign o_pop       = load;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_held_vx   <= '0;
            r_held_vy   <= '0;
            r_held_wz   <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            // Replace held velocities only on a good CRC
            if (load && i_q.head.crc_ok) begin
                r_held_vx <= i_q.head.vx_bits;
                r_held_vy <= i_q.head.vy_bits;
                r_held_wz <= i_q.head.wz_bits;
            end
        end
    end

    // Result payload: fresh velocities on good CRC, held ones otherwise
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result.vx_bits    <= i_q.head.crc_ok ? i_q.head.vx_bits : r_held_vx;
            r_result.vy_bits    <= i_q.head.crc_ok ? i_q.head.vy_bits : r_held_vy;
            r_result.wz_bits    <= i_q.head.crc_ok ? i_q.head.wz_bits : r_held_wz;
            r_result.crc_ok     <= i_q.head.crc_ok;
            r_result.color_flag <= i_q.head.color_flag;
            r_result.start_flag <= i_q.head.start_flag;
        end
    end

endmodule

`default_nettype wire

[rtl/crc16_velocity_frame_receiver_unit.sv]
// ----------------------------------------------------------------------------
// crc16_velocity_frame_receiver_unit: serial velocity frame receiver
// Top level: byte front end, frame queue and result back end.
// ----------------------------------------------------------------------------
// The unit takes one received byte per clock cycle while the frame queue is
// not full. It waits for the start byte, collects 13 payload bytes and a
// high-first Modbus CRC16, and after the last CRC byte emits one result:
// three little-endian velocity words, crc_ok and two flag bits from the last
// payload byte. Velocities are replaced only on a good CRC; otherwise the
// last good values repeat. The byte rate of one per cycle is set by the
// combinational eight-step CRC update in the front end. Each completed frame
// is queued and then registered at the output. Input stalls only while the
// two-entry frame queue is full, which happens only when the output side
// holds stall for a long time. The start byte register resets to 0x5A and
// may be rewritten any time the unit is idle; the write port is always ready.
`default_nettype none

module crc16_velocity_frame_receiver_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte input
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_rx_byte,
    // start byte register
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_start_byte,
    // result output
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_vx_bits,
    output logic [31:0]      o_vy_bits,
    output logic [31:0]      o_wz_bits,
    output logic             o_crc_ok,
    output logic             o_color_flag,
    output logic             o_start_flag
);
    import cvfr_pkg::*;

    logic       q_full;
    logic       push, pop;
    logic       in_accept;
    t_frame     push_data;
    t_q_status  q_status;
    t_frame     result;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign in_accept   = i_in_valid && !q_full;

    cvfr_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_rx_byte        (i_rx_byte),
        .i_cfg_write      (i_cfg_valid),
        .i_cfg_start_byte (i_cfg_start_byte),
        .o_push           (push),
        .o_push_data      (push_data)
    );

    cvfr_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_status    (q_status)
    );

    cvfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q         (q_status),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_result    (result)
    );

    // Unpack result onto the output ports
    assign o_vx_bits    = result.vx_bits;
    assign o_vy_bits    = result.vy_bits;
    assign o_wz_bits    = result.wz_bits;
    assign o_crc_ok     = result.crc_ok;
    assign o_color_flag = result.color_flag;
    assign o_start_flag = result.start_flag;

endmodule

`default_nettype wire

[rtl/cvfr_checker.sv]
// ----------------------------------------------------------------------------
// cvfr_checker: port-level checks for the velocity frame receiver
// Watches the top level's ports over time; attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module cvfr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [31:0] o_vx_bits,
    input wire logic [31:0] o_vy_bits,
    input wire logic [31:0] o_wz_bits,
    input wire logic        o_crc_ok,
    input wire logic        o_color_flag,
    input wire logic        o_start_flag
);

    // Reset empties the queue and the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("result or stall left over after reset");

    // A fresh result must be preceded by an accepted input byte
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result appeared without a matching accepted byte");

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_vx_bits)
            && $stable(o_vy_bits) && $stable(o_wz_bits) && $stable(o_crc_ok)
            && $stable(o_color_flag) && $stable(o_start_flag))
        else $error("stalled result changed");

endmodule

bind crc16_velocity_frame_receiver_unit cvfr_checker u_cvfr_checker (.*);

`default_nettype wire

[tb/cvfr_frame_checker.sv]
// ----------------------------------------------------------------------------
// cvfr_frame_checker: result predictor and scoreboard for the frame receiver
// Follows every accepted byte and start byte write. It tracks the frame the
// unit is assembling, predicts the result of each completed frame and
// compares every accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------

module cvfr_frame_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte channel
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [7:0]  i_rx_byte,
    // start byte register channel
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [7:0]  i_cfg_start_byte,
    // result channel
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [31:0] i_vx_bits,
    input  wire logic [31:0] i_vy_bits,
    input  wire logic [31:0] i_wz_bits,
    input  wire logic        i_crc_ok,
    input  wire logic        i_color_flag,
    input  wire logic        i_start_flag,
    // totals for the testbench top
    output int               o_fail_count,
    output int               o_pending,
    output int               o_good_frames,
    output int               o_bad_frames
);
    import cvfr_pkg::*;

    // Tracked copy of the receiver state
    logic [7:0]       start_code;
    logic [POS_W-1:0] frame_pos;
    logic [15:0]      crc_acc;
    logic [7:0]       body [PAYLOAD_BYTES];
    logic [7:0]       crc_hi_rx;
    logic [31:0]      vx_hold;
    logic [31:0]      vy_hold;
    logic [31:0]      wz_hold;

    t_frame expected_q [$];
    int     mismatches   = 0;
    int     good_frames  = 0;
    int     bad_frames   = 0;

    // Modbus CRC16, fed one bit at a time, LSB first
    function automatic logic [15:0] modbus_crc_step(input logic [15:0] acc,
                                                    input logic [7:0]  b);
        logic [15:0] r;
        r = acc;
        for (int bit_i = 0; bit_i < 8; bit_i++) begin
            r = (r[0] ^ b[bit_i]) ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    // Role of the next byte, given how far into the frame we are
    function automatic t_byte_kind byte_role(input logic [POS_W-1:0] pos);
        if (pos == POS_HUNT) return BK_HUNT;
        if (pos <= POS_LAST_PL) return BK_PAYLOAD;
        if (pos == POS_CRC_HI) return BK_CRC_HI;
        return BK_CRC_LO;
    endfunction

    // Little-endian word from four payload bytes
    function automatic logic [31:0] le_word(input int base);
        return {body[base + 3], body[base + 2], body[base + 1], body[base]};
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_frame want;
        logic   crc_match;
        if (!i_rst_n) begin
            start_code = START_BYTE_RESET;
            frame_pos  = POS_HUNT;
            crc_acc    = CRC_INIT;
            vx_hold    = '0;
            vy_hold    = '0;
            wz_hold    = '0;
            expected_q.delete();
        end else begin
            // Take a new start byte; a frame in progress keeps going
            if (i_cfg_valid && i_cfg_ready) begin
                start_code = i_cfg_start_byte;
            end

            // Advance the frame tracker on each accepted byte
            if (i_in_valid && !i_in_stall) begin
                case (byte_role(frame_pos))
                    BK_HUNT: begin
                        if (i_rx_byte == start_code) begin
                            crc_acc   = CRC_INIT;
                            frame_pos = frame_pos + 1'b1;
                        end
                    end
                    BK_PAYLOAD: begin
                        body[frame_pos - 1'b1] = i_rx_byte;
                        crc_acc   = modbus_crc_step(crc_acc, i_rx_byte);
                        frame_pos = frame_pos + 1'b1;
                    end
                    BK_CRC_HI: begin
                        crc_hi_rx = i_rx_byte;
                        frame_pos = frame_pos + 1'b1;
                    end
                    BK_CRC_LO: begin
                        crc_match = (crc_hi_rx == crc_acc[15:8]) && (i_rx_byte == crc_acc[7:0]);
                        // Update held velocities only on a good CRC
                        if (crc_match) begin
                            vx_hold = le_word(VX_BASE);
                            vy_hold = le_word(VY_BASE);
                            wz_hold = le_word(WZ_BASE);
                            good_frames++;
                        end else begin
                            bad_frames++;
                        end
                        want.vx_bits    = vx_hold;
                        want.vy_bits    = vy_hold;
                        want.wz_bits    = wz_hold;
                        want.crc_ok     = crc_match;
                        want.color_flag = body[FLAG_BYTE][COLOR_BIT];
                        want.start_flag = body[FLAG_BYTE][START_BIT];
                        expected_q.push_back(want);
                        frame_pos = POS_HUNT;
                        crc_acc   = CRC_INIT;
                    end
                endcase
            end

            // Compare each accepted result with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with none expected, got vx %h vy %h wz %h",
                             $time, i_vx_bits, i_vy_bits, i_wz_bits);
                end else begin
                    want = expected_q.pop_front();
                    check_field("vx_bits", want.vx_bits, i_vx_bits);
                    check_field("vy_bits", want.vy_bits, i_vy_bits);
                    check_field("wz_bits", want.wz_bits, i_wz_bits);
                    check_field("crc_ok", 32'(want.crc_ok), 32'(i_crc_ok));
                    check_field("color_flag", 32'(want.color_flag), 32'(i_color_flag));
                    check_field("start_flag", 32'(want.start_flag), 32'(i_start_flag));
                end
            end
        end

        o_pending     <= expected_q.size();
        o_fail_count  <= mismatches;
        o_good_frames <= good_frames;
        o_bad_frames  <= bad_frames;
    end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench top for crc16_velocity_frame_receiver_unit
// Drives bytes and start byte writes: a short directed opening, then phases
// of random frames (good and bad CRC), line noise and cut-off frames under
// several start bytes, with random idle bursts on both sides and one long
// output hold-off. The checker beside the unit predicts and compares.
// ----------------------------------------------------------------------------

module tb;
    import cvfr_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int NUM_PHASES    = 7;
    localparam int PHASE_BYTES   = 210;
    localparam int FRAME_BYTES   = PAYLOAD_BYTES + 3;
    localparam int HOLD_FRAMES   = 8;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 5000;

    typedef logic [7:0] t_body [PAYLOAD_BYTES];

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_start_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_vx_bits;
    logic [31:0] o_vy_bits;
    logic [31:0] o_wz_bits;
    logic        o_crc_ok;
    logic        o_color_flag;
    logic        o_start_flag;

    int fail_count;
    int pending;
    int good_frames;
    int bad_frames;

    // Stimulus control shared with the output stall process
    logic       in_idle_en;
    logic       out_idle_en;
    logic       hold_req;
    logic [7:0] start_code;
    int         bytes_total;
    int         setting_count;

    crc16_velocity_frame_receiver_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_start_byte (i_cfg_start_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_vx_bits        (o_vx_bits),
        .o_vy_bits        (o_vy_bits),
        .o_wz_bits        (o_wz_bits),
        .o_crc_ok         (o_crc_ok),
        .o_color_flag     (o_color_flag),
        .o_start_flag     (o_start_flag)
    );

    cvfr_frame_checker u_frame_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_start_byte (i_cfg_start_byte),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_vx_bits        (o_vx_bits),
        .i_vy_bits        (o_vy_bits),
        .i_wz_bits        (o_wz_bits),
        .i_crc_ok         (o_crc_ok),
        .i_color_flag     (o_color_flag),
        .i_start_flag     (o_start_flag),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_good_frames    (good_frames),
        .o_bad_frames     (bad_frames)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // Hard limit on run length
    initial begin : watchdog
        #2_000_000;
        $display("%0t: run did not finish in time", $time);
        $display("crc16_velocity_frame_receiver_unit verification failed");
        $finish;
    end

    // Output side: random stall bursts, plus one long hold-off on request
    initial begin : result_stall
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
                i_out_stall <= 1'b0;
            end else if (out_idle_en && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Offer one byte, with an occasional idle burst first; hold until accepted
    task automatic push_byte(input logic [7:0] b);
        if (in_idle_en && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        bytes_total++;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid and wait for every predicted result to drain
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        for (int n = 0; n < DRAIN_LIMIT && pending != 0; n++) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the start byte register once the unit is quiet
    task automatic write_start(input logic [7:0] code);
        settle();
        i_cfg_valid      <= 1'b1;
        i_cfg_start_byte <= code;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        start_code = code;
        setting_count++;
    endtask

    // Random payload; now and then bury the start byte inside it
    task automatic fill_random(output t_body body);
        for (int i = 0; i < PAYLOAD_BYTES; i++) body[i] = 8'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            body[$urandom_range(0, PAYLOAD_BYTES - 1)] = start_code;
        end
    endtask

    // Send a whole frame; a corrupt request flips one CRC bit
    task automatic send_frame(input t_body body, input logic corrupt);
        logic [15:0] crc;
        crc = CRC_INIT;
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            crc = crc ^ {8'h00, body[i]};
            repeat (8) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        end
        if (corrupt) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        push_byte(start_code);
        for (int i = 0; i < PAYLOAD_BYTES; i++) push_byte(body[i]);
        push_byte(crc[15:8]);
        push_byte(crc[7:0]);
    endtask

    initial begin : stimulus
        t_body      body;
        int         phase;
        int         phase_bytes;
        int         pick;
        int         len;
        logic [7:0] noise;

        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_rx_byte        = 8'h00;
        i_cfg_valid      = 1'b0;
        i_cfg_start_byte = 8'h00;
        in_idle_en       = 1'b0;
        out_idle_en      = 1'b0;
        hold_req         = 1'b0;
        start_code       = START_BYTE_RESET;
        bytes_total      = 0;
        setting_count    = 1;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Hunting: bytes other than the start byte are dropped
        push_byte(8'h00);
        push_byte(8'hFF);
        // Start byte inside the payload, extreme bytes, and a broken CRC
        body = '{8'h00, 8'hFF, 8'h5A, 8'h80, 8'h5A, 8'h7F, 8'hFE, 8'h01,
                 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h03};
        send_frame(body, 1'b1);
        // Open a frame under a zero start byte, then change it mid-frame
        write_start(8'h00);
        push_byte(8'h00);
        repeat (5) push_byte(8'($urandom));
        write_start(8'hFF);

        // Random phases, each under its own start byte and idle mix
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                1:       write_start(8'h00);
                2, 4:    write_start(8'($urandom));
                3, 6:    write_start(START_BYTE_RESET);
                5:       write_start(8'hA5);
                default: ;
            endcase
            in_idle_en  = (phase < 5) && (phase != 3);
            out_idle_en = (phase < 5) && (phase != 1);

            // Back-to-back frames while the output side holds off
            if (phase == 2) begin
                in_idle_en = 1'b0;
                hold_req   = 1'b1;
                repeat (HOLD_FRAMES) begin
                    fill_random(body);
                    send_frame(body, 1'b0);
                end
                in_idle_en = 1'b1;
            end

            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                pick = $urandom_range(0, 99);
                if (pick < 85) begin
                    fill_random(body);
                    send_frame(body, pick >= 70);
                    phase_bytes += FRAME_BYTES;
                end else if (pick < 93) begin
                    // Line noise that never matches the start byte
                    repeat ($urandom_range(1, 3)) begin
                        noise = 8'($urandom);
                        push_byte((noise == start_code) ? ~noise : noise);
                    end
                end else begin
                    // Frame cut short; the next bytes fill it out
                    len = $urandom_range(1, PAYLOAD_BYTES + 1);
                    push_byte(start_code);
                    repeat (len) push_byte(8'($urandom));
                    phase_bytes += len + 1;
                end
            end
        end

        settle();
        if (pending != 0) begin
            $display("%0t: %0d predicted results never arrived", $time, pending);
        end
        $display("Summary: %0d bytes over %0d start byte settings, %0d frames (%0d bad CRC)",
                 bytes_total, setting_count, good_frames + bad_frames, bad_frames);
        $display("Summary: idle bursts on both sides and a %0d-cycle output hold-off",
                 LONG_HOLD);
        if (fail_count == 0 && pending == 0) begin
            $display("crc16_velocity_frame_receiver_unit verification clean");
        end else begin
            $display("crc16_velocity_frame_receiver_unit verification failed");
        end
        $finish;
    end

endmodule
